// ===== design/scaled_logo_pixel_shader_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SCALED_LOGO_PIXEL_SHADER_TOP_MACROS_SVH
`define SCALED_LOGO_PIXEL_SHADER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SLPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SLPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define SLPS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/slps_pkg.sv =====
`timescale 1ns / 1ps
package slps_pkg;

  localparam int ADDR_W      = 11;
  localparam int STORE_DEPTH = 2048;
  localparam int BYTE_W      = 8;
  localparam int COLOR_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int DX_W        = 13;
  localparam int PITCH_X     = 243;
  localparam int PITCH_Y     = 323;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_INDEX = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOGO_SIZE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LOGO_ALPHA  = 3'd4;

  localparam logic [2:0]  RST_PANEL_INDEX = 3'd0;
  localparam logic [10:0] RST_CENTER_X    = 11'd64;
  localparam logic [10:0] RST_CENTER_Y    = 11'd64;
  localparam logic [9:0]  RST_LOGO_SIZE   = 10'd148;
  localparam logic [4:0]  RST_LOGO_ALPHA  = 5'd16;
  localparam logic [4:0]  ALPHA_FULL      = 5'd16;

  typedef struct packed {
    logic valid;
    logic load;
    logic pass;
  } stage_ctl_t;

  // Gray ramp: v = a * 17 spread over the RGB565 fields.
  function automatic logic [COLOR_W-1:0] gray565(input logic [3:0] a);
    logic [7:0] v;
    v = {a, a};
    return {v[7:3], v[7:2], v[7:3]};
  endfunction

endpackage

// ===== design/scaled_logo_pixel_shader_top.sv =====
// Pixel transactions are registered through the stage registers and the output register.
// Throughput: one transaction per cycle while in_ready is high; loads produce no result.
// The texel step comes from a bit-serial divider of $clog2(LOGO_SIDE+1)+16 steps.
// in_ready is low while it runs, after each logo_size write and after reset.
// Reset is synchronous: valids drop, config registers reset, store stays unwritten.
`timescale 1ns / 1ps
module scaled_logo_pixel_shader_top
  import slps_pkg::*;
#(
  parameter int LOGO_SIDE  = 64,
  parameter int PANEL_SIDE = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_opcode,
  input  logic [ADDR_W-1:0]      in_logo_addr,
  input  logic [BYTE_W-1:0]      in_logo_byte,
  input  logic [6:0]             in_pixel_x,
  input  logic [6:0]             in_pixel_y,
  input  logic [COLOR_W-1:0]     in_background,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [COLOR_W-1:0]     out_pixel_color,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NW    = $clog2(LOGO_SIDE + 1) + 16;
  localparam int TW    = $clog2(LOGO_SIDE);
  localparam int PW    = DX_W + NW + 1;
  localparam int LIN_W = (2 * TW > ADDR_W + 1) ? 2 * TW : ADDR_W + 1;

  // Configuration
  logic [2:0]  panel_index_r;
  logic [10:0] center_x_r, center_y_r;
  logic [9:0]  logo_size_r;
  logic [4:0]  logo_alpha_r;
  logic        step_go_r, step_go_nxt;
  logic        div_busy, step_busy;
  logic [NW-1:0] step;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_index_r <= RST_PANEL_INDEX;
      center_x_r    <= RST_CENTER_X;
      center_y_r    <= RST_CENTER_Y;
      logo_size_r   <= RST_LOGO_SIZE;
      logo_alpha_r  <= RST_LOGO_ALPHA;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_PANEL_INDEX: panel_index_r <= cfg_data[2:0];
        REG_CENTER_X:    center_x_r    <= cfg_data[10:0];
        REG_CENTER_Y:    center_y_r    <= cfg_data[10:0];
        REG_LOGO_SIZE:   logo_size_r   <= cfg_data[9:0];
        REG_LOGO_ALPHA:  logo_alpha_r  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Kick the divider after reset and after every size write.
  assign step_go_nxt = cfg_wr && (cfg_index == REG_LOGO_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_go_r <= 1'b1;
    end else begin
      step_go_r <= step_go_nxt;
    end
  end

  slps_div #(.LOGO_SIDE(LOGO_SIDE)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (step_go_r),
    .divisor  (logo_size_r),
    .busy     (div_busy),
    .quotient (step)
  );

  assign step_busy = step_go_r || div_busy;

  // Pipeline control: every stage advances together.
  logic out_valid_r;
  logic [COLOR_W-1:0] out_color_r;
  logic adv;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv && !step_busy;

  stage_ctl_t s1_ctl_r, s2_ctl_r, s3_ctl_r, s4_ctl_r;
  stage_ctl_t s1_ctl_nxt;

  // Stage 1: canvas offsets
  logic [DX_W-1:0] ox, oy, cx_ext, cy_ext, half_ext, dx_nxt, dy_nxt;
  logic [DX_W-1:0] s1_dx_r, s1_dy_r;
  logic [ADDR_W-1:0] s1_addr_r, s2_addr_r, s3_addr_r;
  logic [BYTE_W-1:0] s1_byte_r, s2_byte_r, s3_byte_r;
  logic [COLOR_W-1:0] s1_bg_r, s2_bg_r, s3_bg_r, s4_bg_r;

  always_comb begin
    ox       = panel_index_r[0] ? DX_W'(PITCH_X) : '0;
    oy       = DX_W'(panel_index_r[2:1]) * DX_W'(PITCH_Y);
    cx_ext   = {{(DX_W - 11){center_x_r[10]}}, center_x_r};
    cy_ext   = {{(DX_W - 11){center_y_r[10]}}, center_y_r};
    half_ext = DX_W'(logo_size_r[9:1]);
    dx_nxt   = ox - cx_ext + half_ext + DX_W'(in_pixel_x);
    dy_nxt   = oy - cy_ext + half_ext + DX_W'(in_pixel_y);
    s1_ctl_nxt.valid = in_valid && in_ready;
    s1_ctl_nxt.load  = in_opcode == OP_LOAD;
    s1_ctl_nxt.pass  = (9'(in_pixel_x) >= 9'(PANEL_SIDE)) ||
                       (9'(in_pixel_y) >= 9'(PANEL_SIDE)) ||
                       (logo_size_r == '0) || (logo_alpha_r == '0);
  end

  // Stage 2: texel coordinates in signed 21.16
  logic signed [PW-1:0] u_nxt, v_nxt, s2_u_r, s2_v_r;

  assign u_nxt = $signed(s1_dx_r) * $signed({1'b0, step});
  assign v_nxt = $signed(s1_dy_r) * $signed({1'b0, step});

  // Stage 3: bounds and store address
  logic [PW-17:0]    u_hi, v_hi;
  logic [TW-1:0]     tu, tv;
  logic [LIN_W-1:0]  lin;
  logic              inside_nxt;
  logic [ADDR_W-1:0] addr_nxt;
  logic              s3_inside_r, s3_tu0_r, s4_inside_r, s4_tu0_r;

  always_comb begin
    u_hi       = s2_u_r[PW-1:16];
    v_hi       = s2_v_r[PW-1:16];
    tu         = s2_u_r[16 +: TW];
    tv         = s2_v_r[16 +: TW];
    inside_nxt = !s2_u_r[PW-1] && !s2_v_r[PW-1] &&
                 (u_hi < (PW - 16)'(LOGO_SIDE)) && (v_hi < (PW - 16)'(LOGO_SIDE));
    lin        = LIN_W'(tv) * LIN_W'(LOGO_SIDE) + LIN_W'(tu);
    addr_nxt   = s2_ctl_r.load ? s2_addr_r : lin[ADDR_W:1];
  end

  // Store: loads write and pixels read at the same stage, so order is kept.
  logic [BYTE_W-1:0] rd_byte;

  slps_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (adv && s3_ctl_r.valid && s3_ctl_r.load),
    .waddr (s3_addr_r),
    .wdata (s3_byte_r),
    .re    (adv),
    .raddr (s3_addr_r),
    .rdata (rd_byte)
  );

  // Stage 4: ink, alpha and compare
  logic [3:0]         nib, ink, a_lvl;
  logic [4:0]         alpha_c;
  logic [8:0]         ink_alpha;
  logic [COLOR_W-1:0] color_nxt;

  always_comb begin
    nib       = s4_tu0_r ? rd_byte[3:0] : rd_byte[7:4];
    ink       = s4_inside_r ? nib : '0;
    alpha_c   = (logo_alpha_r > ALPHA_FULL) ? ALPHA_FULL : logo_alpha_r;
    ink_alpha = 9'(ink) * 9'(alpha_c);
    a_lvl     = ink_alpha[7:4];
    color_nxt = (!s4_ctl_r.pass && (a_lvl > s4_bg_r[15:12])) ? gray565(a_lvl) : s4_bg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_ctl_r    <= '0;
      s3_ctl_r    <= '0;
      s4_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_ctl_r    <= s1_ctl_nxt;
      s2_ctl_r    <= s1_ctl_r;
      s3_ctl_r    <= s2_ctl_r;
      s4_ctl_r    <= s3_ctl_r;
      out_valid_r <= s4_ctl_r.valid && !s4_ctl_r.load;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx_r     <= dx_nxt;
      s1_dy_r     <= dy_nxt;
      s1_addr_r   <= in_logo_addr;
      s1_byte_r   <= in_logo_byte;
      s1_bg_r     <= in_background;
      s2_u_r      <= u_nxt;
      s2_v_r      <= v_nxt;
      s2_addr_r   <= s1_addr_r;
      s2_byte_r   <= s1_byte_r;
      s2_bg_r     <= s1_bg_r;
      s3_inside_r <= inside_nxt;
      s3_tu0_r    <= tu[0];
      s3_addr_r   <= addr_nxt;
      s3_byte_r   <= s2_byte_r;
      s3_bg_r     <= s2_bg_r;
      s4_inside_r <= s3_inside_r;
      s4_tu0_r    <= s3_tu0_r;
      s4_bg_r     <= s3_bg_r;
      out_color_r <= color_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_color = out_color_r;

endmodule

// ===== design/slps_ram.sv =====
`timescale 1ns / 1ps
module slps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/slps_div.sv =====
`timescale 1ns / 1ps
module slps_div
  import slps_pkg::*;
#(
  parameter int LOGO_SIDE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [9:0]                          divisor,
  output logic                                busy,
  output logic [$clog2(LOGO_SIDE+1)+15:0]     quotient
);

  localparam int NW    = $clog2(LOGO_SIDE + 1) + 16;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [NW-1:0] DIVIDEND = NW'(LOGO_SIDE) << 16;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [9:0]       rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [10:0]      trial, diff;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    diff     = trial - {1'b0, divisor};
    ge       = trial >= {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW);
      rem_nxt  = '0;
      quo_nxt  = DIVIDEND;
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNT_W'(1);
      rem_nxt  = ge ? diff[9:0] : trial[9:0];
      quo_nxt  = {quo_r[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== design/slps_checker.sv =====
`timescale 1ns / 1ps
`include "scaled_logo_pixel_shader_top_macros.svh"
module slps_checker
  import slps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COLOR_W-1:0]     out_pixel_color,
  input logic                   cfg_valid,
  input logic                   cfg_ready,
  input logic [CFG_INDEX_W-1:0] cfg_index
);

  // Reset empties the result register.
  `SLPS_ASSERT_ALWAYS_NEXT(a_rst_clears_out, clk, !rst_n, !out_valid)

  // Configuration writes are never back-pressured.
  `SLPS_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

  // A size write restarts the step divider, which blocks input.
  `SLPS_ASSERT_NEXT(a_size_blocks_in, clk, rst_n, cfg_valid && cfg_ready && cfg_index == REG_LOGO_SIZE, !in_ready)

  // Hold a stalled result.
  `SLPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_color))

endmodule

bind scaled_logo_pixel_shader_top slps_checker u_slps_checker (.*);

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import slps_pkg::*;

  localparam int LOGO_SIDE       = 64;
  localparam int PANEL_SIDE      = 128;
  localparam int PHASES          = 12;
  localparam int CALLS_PER_PHASE = 56;
  localparam int FLOOD_CALLS     = 45;
  localparam int PRESSURE_PHASE  = 7;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 400000;

  // Tracks the logo store and registers, and the colors still owed by the block.
  class pixel_shade_tracker;
    logic [7:0]         logo_bytes [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    logic [2:0]         panel;
    logic signed [10:0] cx;
    logic signed [10:0] cy;
    logic [9:0]         size;
    logic [4:0]         alpha;
    logic [15:0]        colors_due [$];
    int                 errors;

    function new();
      panel  = RST_PANEL_INDEX;
      cx     = RST_CENTER_X;
      cy     = RST_CENTER_Y;
      size   = RST_LOGO_SIZE;
      alpha  = RST_LOGO_ALPHA;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PANEL_INDEX: panel = data[2:0];
        REG_CENTER_X:    cx    = data;
        REG_CENTER_Y:    cy    = data;
        REG_LOGO_SIZE:   size  = data[9:0];
        REG_LOGO_ALPHA:  alpha = data[4:0];
        default: ;
      endcase
    endfunction

    // Return 1 when the pixel samples a texel inside the logo.
    function bit logo_hit(input logic [6:0] px, input logic [6:0] py,
                          output logic [10:0] addr, output bit odd);
      longint step, half, ox, oy, u, v, lim;
      addr = '0;
      odd  = 1'b0;
      if (size == 0 || alpha == 0) return 1'b0;
      lim  = longint'(LOGO_SIDE) << 16;
      step = lim / longint'(size);
      half = longint'(size) / 2;
      ox   = panel[0] ? longint'(PITCH_X) : 0;
      oy   = longint'(panel[2:1]) * PITCH_Y;
      u    = (ox - (longint'(cx) - half)) * step + longint'(px) * step;
      v    = (oy - (longint'(cy) - half)) * step + longint'(py) * step;
      if (u < 0 || v < 0 || u >= lim || v >= lim) return 1'b0;
      u    = u >>> 16;
      v    = v >>> 16;
      addr = 11'((v * LOGO_SIDE + u) >> 1);
      odd  = u[0];
      return 1'b1;
    endfunction

    function logic [15:0] shade(logic [6:0] px, logic [6:0] py, logic [15:0] bg);
      logic [10:0] addr;
      bit          odd;
      int          ink, lvl, gray;
      if (!logo_hit(px, py, addr, odd)) return bg;
      ink = odd ? int'(logo_bytes[addr][3:0]) : int'(logo_bytes[addr][7:4]);
      if (ink == 0) return bg;
      lvl = (ink * (alpha > ALPHA_FULL ? int'(ALPHA_FULL) : int'(alpha))) >> 4;
      if (lvl <= int'(bg[15:12])) return bg;
      gray = (lvl * 17) & 'hFF;
      return 16'(((gray & 'hF8) << 8) | ((gray & 'hFC) << 3) | (gray >> 3));
    endfunction

    function void note_input(logic op, logic [10:0] addr, logic [7:0] data,
                             logic [6:0] px, logic [6:0] py, logic [15:0] bg);
      if (op == OP_LOAD) begin
        logo_bytes[addr] = data;
        written[addr]    = 1'b1;
      end else begin
        colors_due.push_back(shade(px, py, bg));
      end
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      if (colors_due.size() == 0) begin
        $display("%0t: pixel_color expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = colors_due.pop_front();
      if (got !== want) begin
        $display("%0t: pixel_color expected %h actual %h", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return colors_due.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_opcode;
  logic [ADDR_W-1:0]      in_logo_addr;
  logic [BYTE_W-1:0]      in_logo_byte;
  logic [6:0]             in_pixel_x;
  logic [6:0]             in_pixel_y;
  logic [COLOR_W-1:0]     in_background;
  logic                   out_valid;
  logic                   out_ready;
  logic [COLOR_W-1:0]     out_pixel_color;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pixel_shade_tracker sb = new();
  bit hold_req    = 1'b0;
  bit flood       = 1'b0;
  int steady_left = 0;
  int cycle_count = 0;

  scaled_logo_pixel_shader_top #(
    .LOGO_SIDE(LOGO_SIDE),
    .PANEL_SIDE(PANEL_SIDE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_logo_addr(in_logo_addr),
    .in_logo_byte(in_logo_byte),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .in_background(in_background),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pixel_color(out_pixel_color),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_pixel_color);
  end

  // Receiver: random runs of ready and stall, plus one long hold-off on request.
  initial begin : ready_driver
    int run_left;
    int r;
    bit level;
    run_left  = 0;
    level     = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
        run_left = 0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          if (r < 50) begin
            level    = 1'b1;
            run_left = $urandom_range(1, 8);
          end else if (r < 60) begin
            level    = 1'b1;
            run_left = $urandom_range(20, 60);
          end else if (r < 92) begin
            level    = 1'b0;
            run_left = $urandom_range(1, 3);
          end else begin
            level    = 1'b0;
            run_left = $urandom_range(10, 40);
          end
        end
        out_ready <= level;
        run_left--;
      end
    end
  end

  task automatic send_item(logic op, logic [10:0] addr, logic [7:0] data,
                           logic [6:0] px, logic [6:0] py, logic [15:0] bg);
    int gap;
    int r;
    gap = 0;
    if (flood) begin
      gap = 0;
    end else if (steady_left > 0) begin
      steady_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 3) steady_left = $urandom_range(20, 60);
      else if (r < 55) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 50);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_logo_addr  <= addr;
    in_logo_byte  <= data;
    in_pixel_x    <= px;
    in_pixel_y    <= py;
    in_background <= bg;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, addr, data, px, py, bg);
  endtask

  task automatic load_byte(logic [10:0] addr, logic [7:0] data);
    send_item(OP_LOAD, addr, data, 7'($urandom), 7'($urandom), 16'($urandom));
  endtask

  // Fill the sampled store byte first when it has never been written.
  task automatic shade_pixel(logic [6:0] px, logic [6:0] py, logic [15:0] bg,
                             logic [7:0] fill);
    logic [10:0] addr;
    bit          odd;
    if (sb.logo_hit(px, py, addr, odd) && !sb.written[addr]) load_byte(addr, fill);
    send_item(OP_PIXEL, 11'($urandom), 8'($urandom), px, py, bg);
  endtask

  task automatic random_item();
    int          half, ox, oy, lo_x, hi_x, lo_y, hi_y;
    logic [6:0]  px, py;
    logic [15:0] bg;
    if ($urandom_range(0, 99) < 15) begin
      load_byte(11'($urandom), 8'($urandom));
      return;
    end
    half = int'(sb.size) / 2;
    ox   = sb.panel[0] ? PITCH_X : 0;
    oy   = int'(sb.panel[2:1]) * PITCH_Y;
    lo_x = int'(sb.cx) - half - ox;
    hi_x = lo_x + int'(sb.size) - 1;
    lo_y = int'(sb.cy) - half - oy;
    hi_y = lo_y + int'(sb.size) - 1;
    if (lo_x < 0) lo_x = 0;
    if (lo_y < 0) lo_y = 0;
    if (hi_x > PANEL_SIDE - 1) hi_x = PANEL_SIDE - 1;
    if (hi_y > PANEL_SIDE - 1) hi_y = PANEL_SIDE - 1;
    px = 7'($urandom);
    py = 7'($urandom);
    // Aim most pixels at the part of the panel the logo covers.
    if ($urandom_range(0, 99) < 75 && lo_x <= hi_x && lo_y <= hi_y) begin
      px = 7'($urandom_range(hi_x, lo_x));
      py = 7'($urandom_range(hi_y, lo_y));
    end
    bg = 16'($urandom);
    if ($urandom_range(0, 1)) bg[15:12] = 4'($urandom_range(0, 3));
    shade_pixel(px, py, bg, 8'($urandom));
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  // Unused upper data bits get random values; the block must ignore them.
  task automatic apply_setting(int panel, int cx, int cy, int size, int alpha);
    write_reg(REG_PANEL_INDEX, {8'($urandom), 3'(panel)});
    write_reg(REG_CENTER_X, 11'(cx));
    write_reg(REG_CENTER_Y, 11'(cy));
    write_reg(REG_LOGO_SIZE, {1'($urandom), 10'(size)});
    write_reg(REG_LOGO_ALPHA, {6'($urandom), 5'(alpha)});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain every owed color, then let trailing loads finish.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int panel, cx, cy, size, alpha;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_LOAD;
    in_logo_addr  = '0;
    in_logo_byte  = '0;
    in_pixel_x    = '0;
    in_pixel_y    = '0;
    in_background = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_PANEL_INDEX;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset registers.
    load_byte(11'h000, 8'hFF);
    load_byte(11'h7FF, 8'h00);
    load_byte(11'h555, 8'hA5);
    load_byte(11'h2AA, 8'h5A);
    shade_pixel(7'd0, 7'd0, 16'h0000, 8'hFF);
    shade_pixel(7'd127, 7'd127, 16'hFFFF, 8'hFF);
    shade_pixel(7'd20, 7'd0, 16'h0000, 8'h00);
    shade_pixel(7'd64, 7'd64, 16'h7FFF, 8'h9E);
    shade_pixel(7'd85, 7'd42, 16'h8000, 8'h3C);
    shade_pixel(7'd42, 7'd85, 16'h1234, 8'hC3);
    shade_pixel(7'd3, 7'd127, 16'h0F0F, 8'h11);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      panel = $urandom_range(0, 7);
      size  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1023) : $urandom_range(8, 200);
      alpha = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
      case (p)
        0: begin
          panel = RST_PANEL_INDEX;
          size  = RST_LOGO_SIZE;
          alpha = RST_LOGO_ALPHA;
        end
        1: begin
          size  = 1;
          alpha = 31;
        end
        2: begin
          panel = 7;
          size  = 1023;
          alpha = 1;
        end
        3: size = 0;
        4: alpha = 0;
        default: ;
      endcase
      cx = (panel % 2) * PITCH_X + int'($urandom_range(0, PANEL_SIDE - 1));
      cy = (panel / 2) * PITCH_Y + int'($urandom_range(0, PANEL_SIDE - 1));
      if (cy > 1023) cy = 1023;
      if (p == 0) begin
        cx = RST_CENTER_X;
        cy = RST_CENTER_Y;
      end
      if (p == 5) begin
        cx = -1024;
        cy = 1023;
      end
      if (p == 6) begin
        cx   = 1023;
        cy   = -1024;
        size = 1023;
      end
      apply_setting(panel, cx, cy, size, alpha);
      if (p == PRESSURE_PHASE) begin
        hold_req = 1'b1;
        flood    = 1'b1;
      end
      for (int k = 0; k < CALLS_PER_PHASE; k++) begin
        if (k == FLOOD_CALLS) flood = 1'b0;
        random_item();
      end
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/slps_pkg.sv
design/slps_ram.sv
design/slps_div.sv
design/scaled_logo_pixel_shader_top.sv
design/slps_checker.sv
bench/testbench.sv
